### rtl/velocity_ramp_profile_top_defines.svh
// ----------------------------------------------------------------------------
// Velocity ramp profile assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef VELOCITY_RAMP_PROFILE_TOP_DEFINES_SVH
`define VELOCITY_RAMP_PROFILE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define VRP_ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("velocity ramp profile assertion failed");
`define VRP_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("velocity ramp profile assertion failed");
`else
`define VRP_ASSERT_IMPL(label, pre, post)
`define VRP_ASSERT_NEXT(label, pre, post)
`endif

`endif

### rtl/vrp_pkg.sv
// ----------------------------------------------------------------------------
// Velocity ramp profile package
// Widths, register codes, pipeline types and the divider step function.
// ----------------------------------------------------------------------------
`default_nettype none

package vrp_pkg;

  localparam int VEL_WIDTH  = 16;
  localparam int DIST_WIDTH = 24;
  localparam int TIME_WIDTH = 16;

  localparam int STEP_SHIFT = TIME_WIDTH + 1;
  localparam int CRUISE_W   = VEL_WIDTH - 1;
  localparam int SQ_W       = 2 * CRUISE_W;
  localparam int PROD_W     = SQ_W + TIME_WIDTH;
  localparam int Y_W        = PROD_W - STEP_SHIFT;
  localparam int PN_W       = CRUISE_W + DIST_WIDTH;
  localparam int NUM_W      = (Y_W > PN_W) ? Y_W : PN_W;
  localparam int DIV_STAGES = (VEL_WIDTH + 1) / 2;
  localparam int QUO_W      = 2 * DIV_STAGES;
  localparam int REM_W      = DIST_WIDTH + 2;
  localparam int SUM_W      = VEL_WIDTH + 2;
  localparam int LATENCY    = DIV_STAGES + 5;

  localparam int CFG_W0     = (DIST_WIDTH > VEL_WIDTH) ? DIST_WIDTH : VEL_WIDTH;
  localparam int CFG_W      = (CFG_W0 > TIME_WIDTH) ? CFG_W0 : TIME_WIDTH;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CRUISE_W-1:0]   CRUISE_RST = CRUISE_W'(256);
  localparam logic [DIST_WIDTH-1:0] RAMP_RST   = DIST_WIDTH'(256);
  localparam logic [VEL_WIDTH-1:0]  MIN_RST    = '0;
  localparam logic [TIME_WIDTH-1:0] STEP_RST   = TIME_WIDTH'(6554);
  localparam logic [VEL_WIDTH-1:0]  POS_MAX    = {1'b0, {(VEL_WIDTH-1){1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIN_CRUISE,
    REG_LIN_RAMP,
    REG_LIN_MIN,
    REG_ANG_CRUISE,
    REG_ANG_RAMP,
    REG_ANG_MIN,
    REG_STEP_TIME
  } cfg_reg_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] lq;
  } div_lane_t;

  typedef struct packed {
    logic [VEL_WIDTH-1:0]  vel;
    logic [VEL_WIDTH-1:0]  vmin;
    logic [CRUISE_W-1:0]   cruise;
    logic [DIST_WIDTH-1:0] ramp;
    logic                  short_move;
    logic                  accel;
    logic                  zero;
    logic                  sat;
  } item_t;

  typedef struct packed {
    item_t     item;
    div_lane_t dv;
    div_lane_t pk;
  } div_data_t;

  // One restoring division step: shift in the next dividend bit, subtract if it fits.
  function automatic div_lane_t div_step(div_lane_t lane, logic [REM_W-1:0] divisor);
    logic [REM_W-1:0] trial;
    div_lane_t        res;
    trial = {lane.rem[REM_W-2:0], lane.lq[QUO_W-1]};
    if (trial >= divisor) begin
      res.rem = trial - divisor;
      res.lq  = {lane.lq[QUO_W-2:0], 1'b1};
    end else begin
      res.rem = trial;
      res.lq  = {lane.lq[QUO_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### rtl/velocity_ramp_profile_top.sv
// ----------------------------------------------------------------------------
// Velocity ramp profile
// Next-velocity generator for a trapezoidal velocity profile.
//
// A transaction is accepted at each rising edge with start high and busy low.
// busy is always low: a new item may be issued in every cycle, and items from
// different axes may be interleaved freely. Each item yields one result, shown
// on next_vel, short_move and accelerating for exactly one cycle while done is
// high. Items pass stage 0, the two shared multiply stages, the eight divider
// stages, each resolving two quotient bits of the step and peak divisions at
// once, then final stages 1 and 2. Throughput is one item per cycle. The
// receiver cannot stall, so results are never held. The user must write
// configuration registers through cfg_wr_en, cfg_index and cfg_wdata only
// while no items are in flight; the block does not enforce it. A synchronous
// reset restores the default settings and drops all items in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "velocity_ramp_profile_top_defines.svh"

module velocity_ramp_profile_top import vrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [VEL_WIDTH-1:0]  cur_vel,
  input  logic [DIST_WIDTH-1:0] move_total,
  input  logic [DIST_WIDTH-1:0] move_left,
  input  logic                  angular_axis,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  output logic                  done,
  output logic [VEL_WIDTH-1:0]  next_vel,
  output logic                  short_move,
  output logic                  accelerating
);

  logic [CRUISE_W-1:0]   lin_cruise_vel;
  logic [DIST_WIDTH-1:0] lin_ramp_dist;
  logic [VEL_WIDTH-1:0]  lin_min_vel;
  logic [CRUISE_W-1:0]   ang_cruise_vel;
  logic [DIST_WIDTH-1:0] ang_ramp_dist;
  logic [VEL_WIDTH-1:0]  ang_min_vel;
  logic [TIME_WIDTH-1:0] step_time;
  cfg_reg_t              cfg_sel;

  logic                  s0_valid;
  logic [VEL_WIDTH-1:0]  s0_vel;
  logic [DIST_WIDTH-1:0] s0_total;
  logic [DIST_WIDTH-1:0] s0_left;
  logic [CRUISE_W-1:0]   s0_cruise;
  logic [DIST_WIDTH-1:0] s0_ramp;
  logic [VEL_WIDTH-1:0]  s0_vmin;

  logic                  s0_short;
  logic                  s0_accel;
  logic                  s1_valid;
  logic [SQ_W-1:0]       s1_sq;
  logic [PN_W-1:0]       s1_pn;
  item_t                 s1_item;

  logic [PROD_W-1:0]     s1_prod;
  logic                  s2_valid;
  logic [Y_W-1:0]        s2_y;
  logic [PN_W-1:0]       s2_pn;
  item_t                 s2_item;

  logic [NUM_W-1:0]      y_ext;
  logic [NUM_W-1:0]      pn_ext;
  logic [NUM_W-1:0]      y_hi;
  logic [NUM_W-1:0]      pn_hi;
  logic [NUM_W-1:0]      sat_limit;

  logic [DIV_STAGES:0]   div_valid;
  div_data_t             div_data [DIV_STAGES+1];

  div_data_t             last;
  logic [VEL_WIDTH-1:0]  dv_mag;
  logic signed [SUM_W-1:0] vel_ext;
  logic signed [SUM_W-1:0] dv_ext;
  logic signed [SUM_W-1:0] sum_next;
  logic [CRUISE_W-1:0]   vmax_next;

  logic                  f1_valid;
  logic signed [SUM_W-1:0] f1_sum;
  logic [CRUISE_W-1:0]   f1_vmax;
  logic signed [VEL_WIDTH-1:0] f1_vmin;
  logic                  f1_short;
  logic                  f1_accel;
  logic                  f1_zero;

  logic signed [SUM_W-1:0] vmin_ext;
  logic signed [SUM_W-1:0] vmax_ext;
  logic signed [SUM_W-1:0] lo_clamp;
  logic signed [SUM_W-1:0] clamped;

  assign busy    = 1'b0;
  assign cfg_sel = cfg_reg_t'(cfg_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_cruise_vel <= CRUISE_RST;
      lin_ramp_dist  <= RAMP_RST;
      lin_min_vel    <= MIN_RST;
      ang_cruise_vel <= CRUISE_RST;
      ang_ramp_dist  <= RAMP_RST;
      ang_min_vel    <= MIN_RST;
      step_time      <= STEP_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_sel)
        REG_LIN_CRUISE: lin_cruise_vel <= cfg_wdata[CRUISE_W-1:0];
        REG_LIN_RAMP:   lin_ramp_dist  <= cfg_wdata[DIST_WIDTH-1:0];
        REG_LIN_MIN:    lin_min_vel    <= cfg_wdata[VEL_WIDTH-1:0];
        REG_ANG_CRUISE: ang_cruise_vel <= cfg_wdata[CRUISE_W-1:0];
        REG_ANG_RAMP:   ang_ramp_dist  <= cfg_wdata[DIST_WIDTH-1:0];
        REG_ANG_MIN:    ang_min_vel    <= cfg_wdata[VEL_WIDTH-1:0];
        REG_STEP_TIME:  step_time      <= cfg_wdata[TIME_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Stage 0: capture the transaction and the settings of its axis.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_vel    <= cur_vel;
    s0_total  <= move_total;
    s0_left   <= move_left;
    s0_cruise <= angular_axis ? ang_cruise_vel : lin_cruise_vel;
    s0_ramp   <= angular_axis ? ang_ramp_dist : lin_ramp_dist;
    s0_vmin   <= angular_axis ? ang_min_vel : lin_min_vel;
  end

  // Stage 1: squares and products, move classification.
  always_comb begin
    s0_short = {1'b0, s0_total} < {s0_ramp, 1'b0};
    if (s0_short) begin
      s0_accel = {s0_left, 1'b0} > {1'b0, s0_total};
    end else begin
      s0_accel = s0_left > s0_ramp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_sq              <= s0_cruise * s0_cruise;
    s1_pn              <= s0_cruise * s0_total;
    s1_item.vel        <= s0_vel;
    s1_item.vmin       <= s0_vmin;
    s1_item.cruise     <= s0_cruise;
    s1_item.ramp       <= s0_ramp;
    s1_item.short_move <= s0_short;
    s1_item.accel      <= s0_accel;
    s1_item.zero       <= (s0_left == '0);
    s1_item.sat        <= 1'b0;
  end

  // Stage 2: scale the squared cruise velocity by the update period.
  assign s1_prod = s1_sq * step_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_y    <= s1_prod[PROD_W-1:STEP_SHIFT];
    s2_pn   <= s1_pn;
    s2_item <= s1_item;
  end

  // Divider set-up: the step saturates when its quotient would not fit.
  always_comb begin
    y_ext     = NUM_W'(s2_y);
    pn_ext    = NUM_W'(s2_pn);
    y_hi      = y_ext >> QUO_W;
    pn_hi     = pn_ext >> QUO_W;
    sat_limit = NUM_W'(s2_item.ramp) << (VEL_WIDTH - 1);

    div_data[0].item     = s2_item;
    div_data[0].item.sat = (y_ext >= sat_limit);
    div_data[0].dv.rem   = y_hi[REM_W-1:0];
    div_data[0].dv.lq    = y_ext[QUO_W-1:0];
    div_data[0].pk.rem   = pn_hi[REM_W-1:0];
    div_data[0].pk.lq    = pn_ext[QUO_W-1:0];
  end

  assign div_valid[0] = s2_valid;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    vrp_div_stage u_div_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (div_valid[g]),
      .in_data   (div_data[g]),
      .out_valid (div_valid[g+1]),
      .out_data  (div_data[g+1])
    );
  end

  // Final stage 1: apply the step and pick the upper limit.
  always_comb begin
    last      = div_data[DIV_STAGES];
    dv_mag    = last.item.sat ? POS_MAX : {1'b0, last.dv.lq[VEL_WIDTH-2:0]};
    vel_ext   = SUM_W'($signed(last.item.vel));
    dv_ext    = $signed(SUM_W'(dv_mag));
    sum_next  = last.item.accel ? (vel_ext + dv_ext) : (vel_ext - dv_ext);
    vmax_next = last.item.short_move ? last.pk.lq[CRUISE_W-1:0] : last.item.cruise;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    f1_sum   <= sum_next;
    f1_vmax  <= vmax_next;
    f1_vmin  <= $signed(last.item.vmin);
    f1_short <= last.item.short_move;
    f1_accel <= last.item.accel;
    f1_zero  <= last.item.zero;
  end

  // Final stage 2: lower clamp first, then the upper clamp.
  always_comb begin
    vmin_ext = SUM_W'(f1_vmin);
    vmax_ext = $signed(SUM_W'(f1_vmax));
    lo_clamp = (f1_sum < vmin_ext) ? vmin_ext : f1_sum;
    clamped  = (lo_clamp > vmax_ext) ? vmax_ext : lo_clamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f1_zero) begin
      next_vel     <= '0;
      short_move   <= 1'b0;
      accelerating <= 1'b0;
    end else begin
      next_vel     <= clamped[VEL_WIDTH-1:0];
      short_move   <= f1_short;
      accelerating <= f1_accel;
    end
  end

  `VRP_ASSERT_IMPL(a_done_latency, done, $past(start, LATENCY))
  `VRP_ASSERT_NEXT(a_stop_on_zero, f1_valid && f1_zero, done && (next_vel == '0) && !accelerating && !short_move)
  `VRP_ASSERT_NEXT(a_max_clamp, f1_valid, $signed(next_vel) <= $signed({1'b0, $past(f1_vmax)}))

endmodule

`default_nettype wire

### rtl/vrp_div_stage.sv
// ----------------------------------------------------------------------------
// Velocity ramp divider stage
// Two restoring steps of the step and peak divisions, then a register.
// ----------------------------------------------------------------------------
`default_nettype none

module vrp_div_stage import vrp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  div_data_t in_data,
  output logic      out_valid,
  output div_data_t out_data
);

  logic [REM_W-1:0] dv_divisor;
  logic [REM_W-1:0] pk_divisor;
  div_data_t        data_next;

  always_comb begin
    dv_divisor     = REM_W'(in_data.item.ramp);
    pk_divisor     = REM_W'({in_data.item.ramp, 1'b0});
    data_next.item = in_data.item;
    data_next.dv   = div_step(div_step(in_data.dv, dv_divisor), dv_divisor);
    data_next.pk   = div_step(div_step(in_data.pk, pk_divisor), pk_divisor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire
